// File: design/sha256_pkg.sv
`default_nettype none
package sha256_pkg;

    localparam int BLOCK_WORDS = 16;
    localparam int ROUNDS      = 64;
    localparam int DIGEST_WORDS = 8;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LENGTH_POS = 6'd56;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } state_t;

    localparam logic OP_ABSORB   = 1'b0;
    localparam logic OP_FINALIZE = 1'b1;

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] i);
        logic [31:0] h;
        case (i)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; 3'd7: h = 32'h5be0cd19;
            default: h = 32'h0;
        endcase
        return h;
    endfunction

endpackage
`default_nettype wire

// File: design/sha256_byte_stream_hasher.sv
`default_nettype none
// Channel   Dir  tdata                         tuser  tlast
// s_axis    in   [7:0] data_byte               op     -
// m_axis    out  [31:0] digest_word,[34:32] idx -      last_word
// Absorb: 1 cycle per byte; the 64th byte of a block starts a compression in the
// round and add states (one shared round unit). Finalize: one cycle per pad byte
// up to byte 56, 8 length bytes, one or two compressions, then 8 output
// transactions. s_axis_tready is low while padding, compressing or emitting.
// Reset (rst_n, async) restores the initial hash and clears the counts.
// Output stalls hold the current digest word until taken.
module sha256_byte_stream_hasher (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // data_byte[7:0]
    input  wire logic        s_axis_tuser,   // op
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // digest_word[31:0], word_index[34:32], zero
    output logic             m_axis_tlast
);
    import sha256_pkg::*;

    state_t state_reg, state_next;
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [5:0]  fill_reg;
    logic [60:0] bytes_reg;
    logic [5:0]  rnd_reg;
    logic [2:0]  out_reg;
    logic        fin_reg;      // compression is part of finalize
    logic [63:0] bits_reg;
    logic        pad_open_reg; // length bytes not yet pushed
    logic        len_blk_reg;  // length goes into the current block

    // byte being pushed this cycle
    logic        push;
    logic [7:0]  pb;
    logic        acc;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign acc = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        push = 1'b0;
        pb   = PAD_BYTE;
        if (state_reg == ST_IDLE && acc)
        begin
            push = 1'b1;
            pb   = (s_axis_tuser == OP_ABSORB) ? s_axis_tdata : PAD_BYTE;
        end
        else if (state_reg == ST_PAD)
        begin
            push = 1'b1;
            if (len_blk_reg && fill_reg >= LENGTH_POS)
                pb = bits_reg[(7 - fill_reg[2:0]) * 8 +: 8];
            else
                pb = 8'h00;
        end
    end

    // round unit
    logic [31:0] wt, s0, s1, t1, t2, wn, w15, w2;
    always_comb
    begin
        w15 = w_reg[1];
        w2  = w_reg[14];
        s0  = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
        s1  = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
        wn  = w_reg[0] + s0 + w_reg[9] + s1;
        wt  = w_reg[0];
        t1  = v_reg[7] + ({v_reg[4][5:0], v_reg[4][31:6]}
              ^ {v_reg[4][10:0], v_reg[4][31:11]} ^ {v_reg[4][24:0], v_reg[4][31:25]})
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + round_k(rnd_reg) + wt;
        t2  = ({v_reg[0][1:0], v_reg[0][31:2]} ^ {v_reg[0][12:0], v_reg[0][31:13]}
              ^ {v_reg[0][21:0], v_reg[0][31:22]})
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (acc)
                begin
                    if (fill_reg == 6'd63)
                        state_next = ST_ROUND;
                    else if (s_axis_tuser == OP_FINALIZE)
                        state_next = ST_PAD;
                end
            ST_PAD:
                if (fill_reg == 6'd63)
                    state_next = ST_ROUND;
            ST_ROUND:
                if (rnd_reg == 6'd63)
                    state_next = ST_ADD;
            ST_ADD:
                if (!fin_reg)
                    state_next = ST_IDLE;
                else if (pad_open_reg)
                    state_next = ST_PAD;
                else
                    state_next = ST_EMIT;
            ST_EMIT:
                if (m_axis_tready && out_reg == 3'd7)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        m_axis_tvalid = (state_reg == ST_EMIT);
        m_axis_tdata  = {5'd0, out_reg, h_reg[out_reg]};
        m_axis_tlast  = (out_reg == 3'd7);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            bytes_reg <= '0;
            rnd_reg   <= '0;
            out_reg   <= '0;
            fin_reg   <= 1'b0;
            pad_open_reg <= 1'b0;
            len_blk_reg  <= 1'b0;
            for (int i = 0; i < 8; i++) h_reg[i] <= init_h(3'(i));
        end
        else
        begin
            state_reg <= state_next;
            if (push)
                fill_reg <= fill_reg + 6'd1;
            if (acc && s_axis_tuser == OP_ABSORB)
                bytes_reg <= bytes_reg + 61'd1;
            if (acc && s_axis_tuser == OP_FINALIZE)
            begin
                fin_reg <= 1'b1;
                pad_open_reg <= 1'b1;
                len_blk_reg  <= (fill_reg < LENGTH_POS);
            end
            if (state_reg == ST_PAD && fill_reg == 6'd63 && len_blk_reg)
                pad_open_reg <= 1'b0;
            if (state_reg == ST_ROUND)
                rnd_reg <= rnd_reg + 6'd1;
            if (state_reg == ST_ADD)
            begin
                for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
                if (fin_reg)
                    len_blk_reg <= 1'b1;
            end
            if (state_reg == ST_EMIT && m_axis_tready)
            begin
                out_reg <= out_reg + 3'd1;
                if (out_reg == 3'd7)
                begin
                    fin_reg   <= 1'b0;
                    fill_reg  <= '0;
                    bytes_reg <= '0;
                    for (int i = 0; i < 8; i++) h_reg[i] <= init_h(3'(i));
                end
            end
        end
    end

    // payload: block buffer / schedule window, working values, length
    always_ff @(posedge clk)
    begin
        if (acc && s_axis_tuser == OP_FINALIZE)
            bits_reg <= {bytes_reg, 3'b000};
        if (push)
            w_reg[fill_reg[5:2]] <= (fill_reg[1:0] == 2'd0) ? {24'd0, pb}
                                    : {w_reg[fill_reg[5:2]][23:0], pb};
        if (push && fill_reg == 6'd63)
            for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
        if (state_reg == ST_ROUND)
        begin
            // window rotates: slot 0 is W[r]
            for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= (rnd_reg < 6'd48) ? wn : w_reg[0];
            v_reg[7] <= v_reg[6]; v_reg[6] <= v_reg[5]; v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2]; v_reg[2] <= v_reg[1]; v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

endmodule
`default_nettype wire

// File: verif/sha256_stream_checker.sv
module sha256_stream_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,
    input  wire logic        s_axis_tuser,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [39:0] m_axis_tdata,
    input  wire logic        m_axis_tlast,
    output int               fail_count,
    output int               digests_pending
);
    import sha256_pkg::*;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_beat_t;

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    logic [31:0]  hash_h [8];
    logic [7:0]   blk_bytes [64];
    logic [5:0]   blk_fill;
    logic [60:0]  msg_len;
    digest_beat_t digest_q [$];

    function automatic logic [31:0] ror32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // one 64-round compression of the buffered block into hash_h
    task automatic run_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + w[i-7]
                 + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
        for (int i = 0; i < 8; i++)
            v[i] = hash_h[i];
        for (int r = 0; r < 64; r++)
        begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[r] + w[r];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_h[i] += v[i];
    endtask

    task automatic append_byte(logic [7:0] b);
        blk_bytes[blk_fill] = b;
        blk_fill++;
        if (blk_fill == 6'd0)
            run_block();
    endtask

    // padding, length, digest words, then back to the initial state
    task automatic close_message();
        logic [63:0] bit_len;
        digest_beat_t beat;
        bit_len = {msg_len, 3'b000};
        append_byte(PAD_BYTE);
        while (blk_fill != LENGTH_POS)
            append_byte(8'h00);
        for (int i = 7; i >= 0; i--)
            append_byte(bit_len[8*i +: 8]);
        for (int i = 0; i < 8; i++)
        begin
            beat.word = hash_h[i];
            beat.idx  = 3'(i);
            beat.last = (i == 7);
            digest_q.push_back(beat);
        end
        hash_h  = SHA_IV;
        blk_fill = '0;
        msg_len  = '0;
    endtask

    initial
    begin
        hash_h     = SHA_IV;
        blk_fill   = '0;
        msg_len    = '0;
        fail_count = 0;
        digests_pending = 0;
    end

    // output transactions checked against the oldest prediction,
    // input transactions feed the predictor
    always @(posedge clk)
    begin
        digest_beat_t exp_beat;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (digest_q.size() == 0)
            begin
                $error("unexpected digest word %h", m_axis_tdata[31:0]);
                fail_count++;
            end
            else
            begin
                exp_beat = digest_q.pop_front();
                if (m_axis_tdata[31:0] !== exp_beat.word)
                begin
                    $error("digest_word: expected %h actual %h",
                        exp_beat.word, m_axis_tdata[31:0]);
                    fail_count++;
                end
                if (m_axis_tdata[34:32] !== exp_beat.idx)
                begin
                    $error("word_index: expected %0d actual %0d",
                        exp_beat.idx, m_axis_tdata[34:32]);
                    fail_count++;
                end
                if (m_axis_tlast !== exp_beat.last)
                begin
                    $error("last_word: expected %0b actual %0b",
                        exp_beat.last, m_axis_tlast);
                    fail_count++;
                end
            end
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            if (s_axis_tuser == OP_FINALIZE)
                close_message();
            else
            begin
                append_byte(s_axis_tdata);
                msg_len++;
            end
        end
        digests_pending = digest_q.size();
    end

endmodule

// File: verif/tb_sha256_byte_stream_hasher.sv
module tb_sha256_byte_stream_hasher;
    import sha256_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;
    int          fail_count;
    int          digests_pending;
    bit          hold_sink;
    bit          stim_done;

    sha256_byte_stream_hasher dut (.*);

    sha256_stream_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    // offer one transaction and hold it until taken
    task automatic send_item(logic op, logic [7:0] b);
        int g;
        g = gap_len();
        if (g != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= b;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic send_message(int len, int fill_mode);
        for (int i = 0; i < len; i++)
            case (fill_mode)
                0: send_item(OP_ABSORB, 8'h00);
                1: send_item(OP_ABSORB, 8'hff);
                default: send_item(OP_ABSORB, 8'($urandom));
            endcase
        send_item(OP_FINALIZE, 8'($urandom));
    endtask

    // sink: random stalls, one long hold-off window
    initial
    begin
        int g;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_sink)
            begin
                m_axis_tready <= 1'b0;
                repeat (300) @(negedge clk);
                hold_sink = 0;
            end
            if (stim_done || $urandom_range(0, 3) != 0)
                m_axis_tready <= 1'b1;
            else
            begin
                m_axis_tready <= 1'b0;
                g = gap_len();
                repeat (g + 1) @(negedge clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        int len;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_ABSORB;
        hold_sink     = 0;
        stim_done     = 0;
        rst_n = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // directed: empty message, short edge-valued messages, finalize with all-ones data
        send_item(OP_FINALIZE, 8'h00);
        send_item(OP_FINALIZE, 8'hff);
        send_message(3, 1);
        send_message(1, 0);
        send_message(2, 2);
        send_message(3, 2);

        // sink stalls long while messages keep arriving
        hold_sink = 1;
        send_message(1, 2);
        send_message(0, 2);

        // random: lengths around the 55/56/64-byte boundaries, multi-block
        for (int n = 0; n < 7; n++)
        begin
            case ($urandom_range(0, 4))
                0: len = $urandom_range(0, 10);
                1: len = $urandom_range(54, 57);
                2: len = $urandom_range(62, 66);
                3: len = $urandom_range(118, 130);
                default: len = $urandom_range(0, 40);
            endcase
            send_message(len, 2);
        end
        s_axis_tvalid <= 1'b0;
        stim_done = 1;

        while (digests_pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: sha256_byte_stream_hasher.f
design/sha256_pkg.sv
design/sha256_byte_stream_hasher.sv
verif/sha256_stream_checker.sv
verif/tb_sha256_byte_stream_hasher.sv
